/* src/asc_pkg.sv */
// Shared types, constants and permutation helpers for the authenticated cipher stream.
package asc_pkg;

  localparam int unsigned LaneW   = 64;
  localparam int unsigned CountW  = 5;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned RndW    = 4;

  localparam logic [CountW-1:0] RateBytes = CountW'(16);
  localparam logic [LaneW-1:0]  AsconIv   = 64'h0000_1000_808c_0001;
  localparam logic [LaneW-1:0]  DsepBit   = 64'h8000_0000_0000_0000;
  localparam logic [RndW-1:0]   RndFirst12 = 4'd0;
  localparam logic [RndW-1:0]   RndFirst8  = 4'd4;
  localparam logic [RndW-1:0]   RndLast    = 4'd11;

  localparam logic [CfgIdxW-1:0] CfgKeyLow  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyHigh = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgDecrypt = 8'd2;

  typedef logic [4:0][LaneW-1:0] lanes_t;

  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_START   = 3'd1,
    OP_AD_FULL = 3'd2,
    OP_AD_PART = 3'd3,
    OP_MSG     = 3'd4,
    OP_FIN     = 3'd5,
    OP_FIN_OUT = 3'd6,
    OP_REJECT  = 3'd7
  } op_e;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_AD_NONE = 5'b00010,
    PH_AD_SOME = 5'b00100,
    PH_MSG     = 5'b01000,
    PH_FIN     = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    POST_NONE = 2'd0,
    POST_DSEP = 2'd1,
    POST_KEY  = 2'd2
  } post_e;

  typedef struct packed {
    op_e                op;
    logic               close_pad;
    logic               close_dsep;
    logic               fin_pad;
    logic [CountW-1:0]  n;
    logic [LaneW-1:0]   b0;
    logic [LaneW-1:0]   b1;
  } cmd_t;

  function automatic logic [LaneW-1:0] asc_rotr(logic [LaneW-1:0] x, int unsigned k);
    return (x >> k) | (x << (LaneW - k));
  endfunction

  function automatic lanes_t asc_round(lanes_t s, logic [RndW-1:0] r);
    logic [LaneW-1:0] a0, a1, a2, a3, a4, b0, b1, b2, b3, b4;
    lanes_t o;
    a0 = s[0];
    a1 = s[1];
    a2 = s[2] ^ {56'd0, ~r, r};
    a3 = s[3];
    a4 = s[4];
    a0 = a0 ^ a4;
    a4 = a4 ^ a3;
    a2 = a2 ^ a1;
    b0 = a0 ^ (~a1 & a2);
    b1 = a1 ^ (~a2 & a3);
    b2 = a2 ^ (~a3 & a4);
    b3 = a3 ^ (~a4 & a0);
    b4 = a4 ^ (~a0 & a1);
    b1 = b1 ^ b0;
    b0 = b0 ^ b4;
    b3 = b3 ^ b2;
    b2 = ~b2;
    o[0] = b0 ^ asc_rotr(b0, 19) ^ asc_rotr(b0, 28);
    o[1] = b1 ^ asc_rotr(b1, 61) ^ asc_rotr(b1, 39);
    o[2] = b2 ^ asc_rotr(b2, 1) ^ asc_rotr(b2, 6);
    o[3] = b3 ^ asc_rotr(b3, 10) ^ asc_rotr(b3, 17);
    o[4] = b4 ^ asc_rotr(b4, 7) ^ asc_rotr(b4, 41);
    return o;
  endfunction

  function automatic logic [LaneW-1:0] asc_byte_mask(logic [3:0] k);
    logic [LaneW-1:0] m;
    if (k >= 4'd8) begin
      m = '1;
    end else begin
      m = (LaneW'(1) << {k[2:0], 3'b000}) - LaneW'(1);
    end
    return m;
  endfunction

  function automatic logic [LaneW-1:0] asc_pad_word(logic [2:0] b);
    return LaneW'(1) << {b, 3'b000};
  endfunction

endpackage

/* src/ascon_aead128_stream.sv */
// Top level of the streaming authenticated cipher: registers, front end, queue and engine.
//
// Channel   Direction  Handshake              Contents
// in        input      in_valid_i/in_ready_o  kind, block halves, byte count
// out       output     out_valid_o/out_ready_i data or tag halves, byte count, flags
// cfg       input      cfg_we_i               key halves and decrypt mode
//
// A full data block runs eight rounds of the single round unit after it is dispatched.
// A start word and a finalize word each run the full permutation on the round unit.
// Reset clears the state, the phase, the queue and the output valid flag at once.
// The queue holds words while the engine runs, and the output register holds a result
// while the engine carries on until the next result is due.
module ascon_aead128_stream import asc_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic [LaneW-1:0]   block_low_i,
  input  logic [LaneW-1:0]   block_high_i,
  input  logic [CountW-1:0]  byte_count_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [LaneW-1:0]   out_low_o,
  output logic [LaneW-1:0]   out_high_o,
  output logic [CountW-1:0]  out_bytes_o,
  output logic               is_tag_o,
  output logic               tag_ok_o,
  output logic               status_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [LaneW-1:0]   cfg_data_i
);

  logic [LaneW-1:0] key_low_q, key_high_q;
  logic decrypt_q;
  logic push, pop, q_full, q_valid;
  cmd_t front_cmd, q_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      decrypt_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgKeyLow:  key_low_q  <= cfg_data_i;
        CfgKeyHigh: key_high_q <= cfg_data_i;
        CfgDecrypt: decrypt_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  asc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .block_low_i  (block_low_i),
    .block_high_i (block_high_i),
    .byte_count_i (byte_count_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (front_cmd)
  );

  asc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  asc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .pop_o       (pop),
    .key_low_i   (key_low_q),
    .key_high_i  (key_high_q),
    .decrypt_i   (decrypt_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_low_o   (out_low_o),
    .out_high_o  (out_high_o),
    .out_bytes_o (out_bytes_o),
    .is_tag_o    (is_tag_o),
    .tag_ok_o    (tag_ok_o),
    .status_o    (status_o)
  );

  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (out_low_o == '0 && out_high_o == '0 && !is_tag_o &&
                                   out_bytes_o == '0))
    else $error("rejected word carries data");

  a_tag_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_tag_o) |-> (out_bytes_o == RateBytes && !status_o))
    else $error("tag result with wrong byte count");

  a_tag_ok_decrypt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && tag_ok_o) |-> (is_tag_o && decrypt_q))
    else $error("tag match flag outside a decrypt tag");

endmodule

/* src/asc_front.sv */
// Front end: accepts words, tracks the session phase and turns each word into a command.
module asc_front import asc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        kind_i,
  input  logic [LaneW-1:0]  block_low_i,
  input  logic [LaneW-1:0]  block_high_i,
  input  logic [CountW-1:0] byte_count_i,
  input  logic              q_full_i,
  output logic              push_o,
  output cmd_t              cmd_o
);

  phase_e phase_q, phase_d;
  logic [CountW-1:0] n_sat;
  logic ad_open;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign n_sat      = (byte_count_i > RateBytes) ? RateBytes : byte_count_i;
  assign ad_open    = (phase_q == PH_AD_NONE) || (phase_q == PH_AD_SOME);

  always_comb begin
    cmd_o            = '0;
    cmd_o.op         = OP_NOP;
    cmd_o.n          = n_sat;
    cmd_o.b0         = block_low_i;
    cmd_o.b1         = block_high_i;
    phase_d          = phase_q;
    if (kind_i == 2'd0) begin
      cmd_o.op = OP_START;
      phase_d  = PH_AD_NONE;
    end else if ((phase_q == PH_IDLE) || (kind_i == 2'd1 && !ad_open) ||
                 (kind_i == 2'd2 && phase_q == PH_FIN)) begin
      cmd_o.op = OP_REJECT;
    end else if (kind_i == 2'd1) begin
      if (n_sat == RateBytes) begin
        cmd_o.op = OP_AD_FULL;
        phase_d  = PH_AD_SOME;
      end else if (n_sat == '0) begin
        cmd_o.close_pad  = (phase_q == PH_AD_SOME);
        cmd_o.close_dsep = 1'b1;
        phase_d          = PH_MSG;
      end else begin
        cmd_o.op = OP_AD_PART;
        phase_d  = PH_MSG;
      end
    end else begin
      cmd_o.close_pad  = (phase_q == PH_AD_SOME);
      cmd_o.close_dsep = ad_open;
      if (kind_i == 2'd2) begin
        cmd_o.op = OP_MSG;
        phase_d  = (n_sat == RateBytes) ? PH_MSG : PH_FIN;
      end else begin
        cmd_o.op      = OP_FIN;
        cmd_o.fin_pad = (phase_q != PH_FIN);
        phase_d       = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else if (push_o) begin
      phase_q <= phase_d;
    end
  end

endmodule

/* src/asc_queue.sv */
// Short command queue between the front end and the permutation engine.
module asc_queue import asc_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

/* src/asc_back.sv */
// Back end: executes commands on the state with one permutation round per cycle.
module asc_back import asc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  cmd_t              q_cmd_i,
  output logic              pop_o,
  input  logic [LaneW-1:0]  key_low_i,
  input  logic [LaneW-1:0]  key_high_i,
  input  logic              decrypt_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [LaneW-1:0]  out_low_o,
  output logic [LaneW-1:0]  out_high_o,
  output logic [CountW-1:0] out_bytes_o,
  output logic              is_tag_o,
  output logic              tag_ok_o,
  output logic              status_o
);

  typedef enum logic [1:0] {
    S_RUN  = 2'b01,
    S_PERM = 2'b10
  } state_e;

  state_e state_q, state_d;
  lanes_t lanes_q, lanes_d, rnd_out;
  cmd_t cmd_q, cmd_d;
  logic [RndW-1:0] rnd_q, rnd_d;
  post_e post_q, post_d;

  logic out_valid_q, out_valid_d, out_load, out_free;
  logic [LaneW-1:0] out_low_q, out_low_d, out_high_q, out_high_d;
  logic [CountW-1:0] out_bytes_q, out_bytes_d;
  logic is_tag_q, is_tag_d, tag_ok_q, tag_ok_d, status_q, status_d;

  logic [LaneW-1:0] m0, m1, c0, c1, w0, w1;
  logic [3:0] n_hi;

  assign out_free = !out_valid_q || out_ready_i;
  assign n_hi = (cmd_q.n > CountW'(8)) ? 4'(cmd_q.n - CountW'(8)) : 4'd0;
  assign m0   = asc_byte_mask((cmd_q.n >= CountW'(8)) ? 4'd8 : cmd_q.n[3:0]);
  assign m1   = asc_byte_mask(n_hi);
  assign c0   = cmd_q.b0 & m0;
  assign c1   = cmd_q.b1 & m1;
  assign rnd_out = asc_round(lanes_q, rnd_q);

  always_comb begin
    state_d     = state_q;
    lanes_d     = lanes_q;
    cmd_d       = cmd_q;
    rnd_d       = rnd_q;
    post_d      = post_q;
    pop_o       = 1'b0;
    out_load    = 1'b0;
    out_low_d   = out_low_q;
    out_high_d  = out_high_q;
    out_bytes_d = out_bytes_q;
    is_tag_d    = is_tag_q;
    tag_ok_d    = tag_ok_q;
    status_d    = status_q;
    w0          = '0;
    w1          = '0;
    case (state_q)
      S_RUN: begin
        if (cmd_q.close_pad) begin
          lanes_d[0]       = lanes_q[0] ^ asc_pad_word(3'd0);
          rnd_d            = RndFirst8;
          post_d           = POST_DSEP;
          cmd_d.close_pad  = 1'b0;
          cmd_d.close_dsep = 1'b0;
          state_d          = S_PERM;
        end else if (cmd_q.close_dsep) begin
          lanes_d[4]       = lanes_q[4] ^ DsepBit;
          cmd_d.close_dsep = 1'b0;
        end else begin
          case (cmd_q.op)
            OP_NOP: begin
              if (q_valid_i) begin
                pop_o = 1'b1;
                cmd_d = q_cmd_i;
              end
            end
            OP_START: begin
              lanes_d[0] = AsconIv;
              lanes_d[1] = key_low_i;
              lanes_d[2] = key_high_i;
              lanes_d[3] = cmd_q.b0;
              lanes_d[4] = cmd_q.b1;
              rnd_d      = RndFirst12;
              post_d     = POST_KEY;
              cmd_d.op   = OP_NOP;
              state_d    = S_PERM;
            end
            OP_AD_FULL: begin
              lanes_d[0] = lanes_q[0] ^ cmd_q.b0;
              lanes_d[1] = lanes_q[1] ^ cmd_q.b1;
              rnd_d      = RndFirst8;
              post_d     = POST_NONE;
              cmd_d.op   = OP_NOP;
              state_d    = S_PERM;
            end
            OP_AD_PART: begin
              w0 = lanes_q[0] ^ c0;
              w1 = lanes_q[1] ^ c1;
              if (cmd_q.n[3]) begin
                w1 = w1 ^ asc_pad_word(cmd_q.n[2:0]);
              end else begin
                w0 = w0 ^ asc_pad_word(cmd_q.n[2:0]);
              end
              lanes_d[0] = w0;
              lanes_d[1] = w1;
              rnd_d      = RndFirst8;
              post_d     = POST_DSEP;
              cmd_d.op   = OP_NOP;
              state_d    = S_PERM;
            end
            OP_MSG: begin
              if (out_free) begin
                if (decrypt_i) begin
                  out_low_d  = (lanes_q[0] ^ c0) & m0;
                  out_high_d = (lanes_q[1] ^ c1) & m1;
                  w0 = (lanes_q[0] & ~m0) | c0;
                  w1 = (lanes_q[1] & ~m1) | c1;
                end else begin
                  w0 = lanes_q[0] ^ c0;
                  w1 = lanes_q[1] ^ c1;
                  out_low_d  = w0 & m0;
                  out_high_d = w1 & m1;
                end
                out_bytes_d = cmd_q.n;
                is_tag_d    = 1'b0;
                tag_ok_d    = 1'b0;
                status_d    = 1'b0;
                out_load    = 1'b1;
                cmd_d.op    = OP_NOP;
                if (cmd_q.n == RateBytes) begin
                  rnd_d   = RndFirst8;
                  post_d  = POST_NONE;
                  state_d = S_PERM;
                end else if (cmd_q.n[3]) begin
                  w1 = w1 ^ asc_pad_word(cmd_q.n[2:0]);
                end else begin
                  w0 = w0 ^ asc_pad_word(cmd_q.n[2:0]);
                end
                lanes_d[0] = w0;
                lanes_d[1] = w1;
              end
            end
            OP_FIN: begin
              if (cmd_q.fin_pad) begin
                lanes_d[0] = lanes_q[0] ^ asc_pad_word(3'd0);
              end
              lanes_d[2] = lanes_q[2] ^ key_low_i;
              lanes_d[3] = lanes_q[3] ^ key_high_i;
              rnd_d      = RndFirst12;
              post_d     = POST_KEY;
              cmd_d.op   = OP_FIN_OUT;
              state_d    = S_PERM;
            end
            OP_FIN_OUT: begin
              if (out_free) begin
                out_low_d   = lanes_q[3];
                out_high_d  = lanes_q[4];
                out_bytes_d = RateBytes;
                is_tag_d    = 1'b1;
                tag_ok_d    = decrypt_i &&
                              (((lanes_q[3] ^ cmd_q.b0) | (lanes_q[4] ^ cmd_q.b1)) == '0);
                status_d    = 1'b0;
                out_load    = 1'b1;
                cmd_d.op    = OP_NOP;
              end
            end
            OP_REJECT: begin
              if (out_free) begin
                out_low_d   = '0;
                out_high_d  = '0;
                out_bytes_d = '0;
                is_tag_d    = 1'b0;
                tag_ok_d    = 1'b0;
                status_d    = 1'b1;
                out_load    = 1'b1;
                cmd_d.op    = OP_NOP;
              end
            end
            default: begin
              cmd_d.op = OP_NOP;
            end
          endcase
        end
      end
      S_PERM: begin
        lanes_d = rnd_out;
        if (rnd_q == RndLast) begin
          case (post_q)
            POST_DSEP: lanes_d[4] = rnd_out[4] ^ DsepBit;
            POST_KEY: begin
              lanes_d[3] = rnd_out[3] ^ key_low_i;
              lanes_d[4] = rnd_out[4] ^ key_high_i;
            end
            default: lanes_d = rnd_out;
          endcase
          state_d = S_RUN;
        end else begin
          rnd_d = rnd_q + RndW'(1);
        end
      end
      default: state_d = S_RUN;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      lanes_q     <= '0;
      cmd_q       <= '0;
      rnd_q       <= '0;
      post_q      <= POST_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lanes_q     <= lanes_d;
      cmd_q       <= cmd_d;
      rnd_q       <= rnd_d;
      post_q      <= post_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_low_q   <= out_low_d;
    out_high_q  <= out_high_d;
    out_bytes_q <= out_bytes_d;
    is_tag_q    <= is_tag_d;
    tag_ok_q    <= tag_ok_d;
    status_q    <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_low_o   = out_low_q;
  assign out_high_o  = out_high_q;
  assign out_bytes_o = out_bytes_q;
  assign is_tag_o    = is_tag_q;
  assign tag_ok_o    = tag_ok_q;
  assign status_o    = status_q;

endmodule
